/* hw/rtl/pprf_pkg.sv */
`default_nettype none

package pprf_pkg;

  // Image geometry limits.
  localparam int unsigned MaxWidth      = 4096;
  localparam int unsigned BytesPerPixel = 4;
  localparam int unsigned LineDepth     = MaxWidth * BytesPerPixel;
  localparam int unsigned ColW          = $clog2(LineDepth);
  localparam int unsigned RowBytesW     = ColW + 1;
  localparam int unsigned HistW         = 8 * BytesPerPixel;

  // Register widths and reset values.
  localparam int unsigned WidthW   = 13;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

  // Filter type byte for Paeth.
  localparam logic [7:0] FilterTag = 8'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_e;

  // One input byte after the input register, with everything the filter
  // stage needs from the position counters.
  typedef struct packed {
    logic [7:0]      pixel;
    logic [7:0]      left;
    logic [ColW-1:0] col;
    logic            first;
    logic            col_ge_bpp;
    logic            row_nz;
    logic            img_end;
  } item_t;

endpackage

`default_nettype wire

/* hw/rtl/png_paeth_row_filter_core.sv */
// PNG Paeth filter for 8-bit RGBA images. Bytes enter one per request in
// raster order; each is filtered against the same channel of the previous
// pixel, the byte above and the byte above-left, with neighbors outside the
// image taken as zero, and the difference is sent modulo 256. Every row opens
// with the filter type byte 4 (tuser bit 0 set), which precedes the first
// filtered byte of that row. The block sustains one input byte per cycle
// while the output is not stalled; the first byte of each row is held back
// since its tag and its filtered byte leave through the same output register.
// On its way out a byte passes the input register, which the registered read
// of the 16384-byte line store holding the previous row lines up with, and
// then the output register. A zero width or height counts as one, and a width
// above 4096 pixels counts as 4096. The configuration registers are to be
// written only while the block is idle; cfg_ready_o is always high and
// unknown indexes are ignored.

`default_nettype none

module png_paeth_row_filter_core
  import pprf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] pixel_byte
  // Output stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [7:0] out_byte
  output logic                     m_axis_tlast,   // last_of_run
  output logic [1:0]               m_axis_tuser,   // [0] is_filter_tag, [1] end_of_image
  // Configuration writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic               cfg_write;

  logic               pop;
  logic               item_valid;
  item_t              item;
  logic               rd_en;
  logic [ColW-1:0]    rd_addr;
  logic [7:0]         rd_data;
  logic               wr_en;
  logic [ColW-1:0]    wr_addr;
  logic [7:0]         wr_data;
  logic               out_tag, out_end;

  // Configuration registers take effect on the next byte.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WidthW-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Input register, column and row counters, left-pixel history.
  pprf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_data_i    (s_axis_tdata),
    .s_ready_o   (s_axis_tready),
    .width_i     (width_q),
    .height_i    (height_q),
    .pop_i       (pop),
    .item_valid_o(item_valid),
    .item_o      (item),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  // Previous row. It is read when a byte is accepted and written with that
  // byte when it leaves the filter stage, so within a row the read always
  // runs ahead of the write.
  pprf_ram #(
    .Width(8),
    .Depth(LineDepth)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Paeth predictor, tag insertion and output register.
  pprf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .above_i     (rd_data),
    .pop_o       (pop),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (m_axis_tdata),
    .m_tag_o     (out_tag),
    .m_last_o    (m_axis_tlast),
    .m_end_o     (out_end)
  );

  assign m_axis_tuser = {out_end, out_tag};

endmodule

`default_nettype wire

/* hw/rtl/pprf_ram.sv */
`default_nettype none

module pprf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pprf_front.sv */
`default_nettype none

module pprf_front
  import pprf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  input  wire logic [7:0]         s_data_i,
  output logic                    s_ready_o,
  input  wire logic [WidthW-1:0]  width_i,
  input  wire logic [HeightW-1:0] height_i,
  input  wire logic               pop_i,
  output logic                    item_valid_o,
  output item_t                   item_o,
  output logic                    rd_en_o,
  output logic [ColW-1:0]         rd_addr_o
);

  logic                 accept;
  logic                 item_valid_q, item_valid_d;
  item_t                item_q, item_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [HeightW-1:0]   row_q, row_d;
  logic [HistW-1:0]     left_q, left_d;
  logic [WidthW-1:0]    width_eff;
  logic [HeightW-1:0]   height_eff;
  logic [RowBytesW-1:0] row_bytes;
  logic                 row_end;
  logic                 img_end;

  assign s_ready_o = !item_valid_q || pop_i;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    if (width_i == '0) begin
      width_eff = WidthW'(1);
    end else if (width_i > WidthW'(MaxWidth)) begin
      width_eff = WidthW'(MaxWidth);
    end else begin
      width_eff = width_i;
    end
    height_eff = (height_i == '0) ? HeightW'(1) : height_i;
  end

  assign row_bytes = RowBytesW'(width_eff) * RowBytesW'(BytesPerPixel);
  assign row_end   = ({1'b0, col_q} + RowBytesW'(1)) >= row_bytes;
  assign img_end   = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, height_eff});

  always_comb begin
    item_valid_d = item_valid_q;
    item_d       = item_q;
    col_d        = col_q;
    row_d        = row_q;
    left_d       = left_q;
    if (accept) begin
      item_valid_d      = 1'b1;
      item_d.pixel      = s_data_i;
      item_d.col_ge_bpp = col_q >= ColW'(BytesPerPixel);
      item_d.left       = item_d.col_ge_bpp ? left_q[HistW-1 -: 8] : 8'd0;
      item_d.col        = col_q;
      item_d.first      = col_q == '0;
      item_d.row_nz     = row_q != '0;
      item_d.img_end    = img_end;
      if (row_end) begin
        col_d  = '0;
        left_d = '0;
        row_d  = img_end ? '0 : row_q + HeightW'(1);
      end else begin
        col_d  = col_q + ColW'(1);
        left_d = {left_q[HistW-9:0], s_data_i};
      end
    end else if (pop_i) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      left_q       <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      col_q        <= col_d;
      row_q        <= row_d;
      left_q       <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;
  assign rd_en_o      = accept;
  assign rd_addr_o    = col_q;

endmodule

`default_nettype wire

/* hw/rtl/pprf_back.sv */
`default_nettype none

module pprf_back
  import pprf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire item_t           item_i,
  input  wire logic [7:0]      above_i,
  output logic                 pop_o,
  output logic                 wr_en_o,
  output logic [ColW-1:0]      wr_addr_o,
  output logic [7:0]           wr_data_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output logic [7:0]           m_byte_o,
  output logic                 m_tag_o,
  output logic                 m_last_o,
  output logic                 m_end_o
);

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] pa, pb, pc;
    logic        [7:0] r;
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = pa + pb;
    pa = (pa < 0) ? -pa : pa;
    pb = (pb < 0) ? -pb : pb;
    pc = (pc < 0) ? -pc : pc;
    if (pa <= pb && pa <= pc) begin
      r = a;
    end else if (pb <= pc) begin
      r = b;
    end else begin
      r = c;
    end
    return r;
  endfunction

  logic             need_tag, out_free, emit;
  logic [7:0]       b_val, c_val, filt;
  logic             tag_done_q, tag_done_d;
  logic [HistW-1:0] upper_q;
  logic             m_valid_q, m_valid_d;
  logic [7:0]       m_byte_q, m_byte_d;
  logic             m_tag_q, m_tag_d, m_last_q, m_last_d, m_end_q, m_end_d;

  assign need_tag = item_i.first && !tag_done_q;
  assign out_free = !m_valid_q || m_ready_i;
  assign emit     = item_valid_i && out_free;
  assign pop_o    = emit && !need_tag;

  assign b_val = item_i.row_nz ? above_i : 8'd0;
  assign c_val = (item_i.col_ge_bpp && item_i.row_nz) ? upper_q[HistW-1 -: 8] : 8'd0;
  assign filt  = item_i.pixel - paeth(item_i.left, b_val, c_val);

  always_comb begin
    m_valid_d  = m_valid_q;
    m_byte_d   = m_byte_q;
    m_tag_d    = m_tag_q;
    m_last_d   = m_last_q;
    m_end_d    = m_end_q;
    tag_done_d = tag_done_q;
    if (emit) begin
      m_valid_d = 1'b1;
      m_byte_d  = need_tag ? FilterTag : filt;
      m_tag_d   = need_tag;
      m_last_d  = !need_tag;
      m_end_d   = !need_tag && item_i.img_end;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
    if (pop_o) begin
      tag_done_d = 1'b0;
    end else if (emit) begin
      tag_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      tag_done_q <= 1'b0;
    end else begin
      m_valid_q  <= m_valid_d;
      tag_done_q <= tag_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_byte_q <= m_byte_d;
    m_tag_q  <= m_tag_d;
    m_last_q <= m_last_d;
    m_end_q  <= m_end_d;
    if (pop_o) begin
      upper_q <= {upper_q[HistW-9:0], b_val};
    end
  end

  assign wr_en_o   = pop_o;
  assign wr_addr_o = item_i.col;
  assign wr_data_o = item_i.pixel;

  assign m_valid_o = m_valid_q;
  assign m_byte_o  = m_byte_q;
  assign m_tag_o   = m_tag_q;
  assign m_last_o  = m_last_q;
  assign m_end_o   = m_end_q;

endmodule

`default_nettype wire

/* hw/rtl/pprf_checker.sv */
`default_nettype none

module pprf_checker
  import pprf_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic [1:0] m_axis_tuser
);

  // A stalled request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  // A tag carries the Paeth filter type and is never the last of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == FilterTag && !m_axis_tlast)
    else $error("malformed filter tag");

  // End of image only marks a filtered byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("end of image on a tag");

  // A tag taken is followed by the filtered byte of the same input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |=> m_axis_tvalid && !m_axis_tuser[0])
    else $error("tag not followed by its filtered byte");

endmodule

bind png_paeth_row_filter_core pprf_checker u_pprf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;
  import pprf_pkg::*;

  // Indexes beyond the register map; writes to them must leave the geometry alone.
  localparam logic [CfgIdxW-1:0] SpareIdxLo = 2'd2;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 2'd3;

  // One result as it leaves the block: a byte plus its three flags.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_tag;
    logic       run_last;
    logic       img_last;
  } filt_out_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  png_paeth_row_filter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow of the block: geometry registers, previous row, pixel histories
  // and the position counters, all updated at the edge that accepts a request.
  logic [WidthW-1:0]  geo_width  = WidthReset;
  logic [HeightW-1:0] geo_height = HeightReset;
  logic [7:0]         prev_row_bytes [LineDepth];
  logic [HistW-1:0]   left_hist   = '0;
  logic [HistW-1:0]   upleft_hist = '0;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  filt_out_t   filtered_q [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_in       = 0;
  int unsigned tags_seen      = 0;
  int unsigned images_seen    = 0;
  bit          traffic_gaps   = 1'b1;
  int unsigned sink_hold      = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run, even with every stall at its longest.
  initial begin
    #4_000_000;
    $display("png_paeth_row_filter_core test failed");
    $finish;
  end

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, b, c);
    int ia, ib, ic, p, da, db, dc;
    ia = a;
    ib = b;
    ic = c;
    p  = ia + ib - ic;
    da = (p > ia) ? p - ia : ia - p;
    db = (p > ib) ? p - ib : ib - p;
    dc = (p > ic) ? p - ic : ic - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Appends one predicted result to the tail of the outstanding list.
  task automatic queue_result(input filt_out_t res);
    filtered_q.insert(filtered_q.size(), res);
  endtask

  // Works out the results of one accepted byte and advances the shadow state.
  task automatic predict_filtered_byte(input logic [7:0] cur);
    int unsigned w, h, row_len;
    logic [7:0]  a, b, c, filt;
    bit          row_end, img_end;
    w = geo_width;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    h = geo_height;
    if (h == 0) h = 1;
    row_len = w * BytesPerPixel;

    if (col_pos == 0) begin
      queue_result('{byte_val: FilterTag, is_tag: 1'b1, run_last: 1'b0,
                     img_last: 1'b0});
    end
    // Neighbors outside the image read as zero.
    a = (col_pos >= BytesPerPixel) ? left_hist[HistW-1 -: 8] : 8'h00;
    b = (row_pos != 0 && col_pos < LineDepth) ? prev_row_bytes[col_pos] : 8'h00;
    c = (col_pos >= BytesPerPixel && row_pos != 0) ? upleft_hist[HistW-1 -: 8] : 8'h00;
    filt    = cur - paeth_pick(a, b, c);
    row_end = (col_pos + 1 >= row_len);
    img_end = row_end && (row_pos + 1 >= h);
    queue_result('{byte_val: filt, is_tag: 1'b0, run_last: 1'b1,
                   img_last: img_end});

    if (col_pos < LineDepth) prev_row_bytes[col_pos] = cur;
    left_hist   = {left_hist[HistW-9:0], cur};
    upleft_hist = {upleft_hist[HistW-9:0], b};
    if (row_end) begin
      col_pos     = 0;
      left_hist   = '0;
      upleft_hist = '0;
      row_pos     = img_end ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic check_result();
    filt_out_t want;
    if (filtered_q.size() == 0) begin
      note_failure($sformatf("output byte %02h with nothing outstanding", m_axis_tdata));
      return;
    end
    want = filtered_q.pop_front();
    if (m_axis_tdata !== want.byte_val || m_axis_tuser[0] !== want.is_tag ||
        m_axis_tlast !== want.run_last || m_axis_tuser[1] !== want.img_last) begin
      note_failure($sformatf(
        "expected byte %02h tag %0b last %0b end %0b, got byte %02h tag %0b last %0b end %0b",
        want.byte_val, want.is_tag, want.run_last, want.img_last,
        m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]));
    end
    if (want.is_tag) tags_seen++;
    if (want.img_last) images_seen++;
  endtask

  // All handshakes are sampled at the rising edge, results before requests,
  // so the shadow sees exactly what the block's registers see.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        predict_filtered_byte(s_axis_tdata);
        bytes_in++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_IMAGE_WIDTH) geo_width = cfg_data_i[WidthW-1:0];
        else if (cfg_index_i == CFG_IMAGE_HEIGHT) geo_height = cfg_data_i[HeightW-1:0];
      end
    end
  end

  // Output side backpressure: random stall bursts of random length.
  always @(negedge clk_i) begin
    bit ready_nxt;
    if (sink_hold != 0) begin
      sink_hold--;
      ready_nxt = 1'b0;
    end else if (traffic_gaps && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(0, 9);
      ready_nxt = 1'b0;
    end else begin
      ready_nxt = 1'b1;
    end
    m_axis_tready <= ready_nxt;
  end

  // Sends one pixel byte; entered and left at a falling edge. tvalid stays
  // high between back-to-back requests and drops only for an idle burst.
  task automatic push_byte(input logic [7:0] value);
    if (traffic_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops the input and waits until every outstanding result has left.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Partly byte values near a neighbor, partly extremes and random bytes, so that predictor ties come up often.
  function automatic logic [7:0] pick_byte();
    logic [7:0] off;
    off = 8'($urandom_range(0, 4)) - 8'd2;
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return (col_pos >= BytesPerPixel) ? left_hist[HistW-1 -: 8] + off : 8'($urandom);
      3: return (row_pos != 0) ? prev_row_bytes[col_pos] + off : 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic finish_image();
    while (col_pos != 0 || row_pos != 0) push_byte(pick_byte());
  endtask

  // Reset geometry, then a width cut below the current column, which ends its row
  // at once, and a height cut below the current row, which ends the image with that row.
  task automatic test_reset_geometry();
    repeat (6) push_byte(8'($urandom));
    drain_pipeline();
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    push_byte(8'($urandom));
    repeat (4) push_byte(8'($urandom));
    drain_pipeline();
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    finish_image();
  endtask

  // Zero geometry, ignored register indexes, extreme bytes and each way the
  // predictor can choose (left, above, above-left, and a three-way tie).
  task automatic test_extremes();
    logic [7:0] grid [16];
    grid = '{8'd200, 8'd200, 8'd128, 8'd7, 8'd200, 8'd10,  8'd255, 8'd7,
             8'd10,  8'd200, 8'd0,   8'd7, 8'd0,   8'd255, 8'd1,   8'd7};
    drain_pipeline();
    write_reg(CFG_IMAGE_WIDTH, 16'h0000);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0000);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h80);
    push_byte(8'h7F);
    drain_pipeline();
    write_reg(SpareIdxLo, 16'hFFFF);
    write_reg(SpareIdxHi, 16'h5A5A);
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    foreach (grid[i]) push_byte(grid[i]);
  endtask

  // Tallest height, then cut below the current row mid-image.
  task automatic test_tall_image();
    drain_pipeline();
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    repeat (12) push_byte(pick_byte());
    drain_pipeline();
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    finish_image();
  endtask

  // Widest width code saturates to MaxWidth; the first row is then cut short
  // and the second row reads it back from the line store.
  task automatic test_widest_row();
    drain_pipeline();
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    repeat (40) push_byte(pick_byte());
    drain_pipeline();
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    finish_image();
  endtask

  // Whole images of random small geometry; some get a width cut or a height
  // change partway through. Width only grows at an image boundary, so the
  // line store is never read where the current image has not written it.
  task automatic test_random_images(input int unsigned budget, input int unsigned calm_tail);
    int unsigned start, w, h, part;
    start = bytes_in;
    while (bytes_in - start < budget) begin
      if (bytes_in - start + calm_tail >= budget) traffic_gaps = 1'b0;
      case ($urandom_range(0, 19))
        0:       w = 0;
        1, 2, 3: w = $urandom_range(7, 40);
        default: w = $urandom_range(1, 6);
      endcase
      h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
      drain_pipeline();
      write_reg(CFG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
      write_reg(CFG_IMAGE_HEIGHT, 16'(h));
      if ($urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, ((w == 0) ? 1 : w) * BytesPerPixel * ((h == 0) ? 1 : h));
        repeat (part) push_byte(pick_byte());
        drain_pipeline();
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(0, (w == 0) ? 1 : w)));
        end else begin
          write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 6)));
        end
      end
      finish_image();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_geometry();
    test_extremes();
    test_tall_image();
    test_widest_row();
    test_random_images(1250, 250);

    drain_pipeline();
    repeat (10) @(negedge clk_i);
    if (filtered_q.size() != 0) note_failure("results still outstanding at the end");

    $display("Sent %0d pixel bytes; saw %0d row tags and %0d complete images,",
             bytes_in, tags_seen, images_seen);
    $display("from 1x1 up to a saturated width code, with mid-image geometry cuts.");
    if (mismatch_count == 0) begin
      $display("png_paeth_row_filter_core test passed");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("png_paeth_row_filter_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
